@@ rtl/mtc_pkg.sv @@
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types and constants of the transition counter.
// ----------------------------------------------------------------------------
`default_nettype none
package mtc_pkg;
   localparam int SYM_BITS    = 32;
   localparam int PROB_BITS   = 17;
   localparam int TOTAL_BITS  = 24;
   localparam int MAX_SYMBOLS = 64;
   localparam logic [6:0] LIMIT_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEARCH, ST_ADD_RD, ST_ADD_WAIT, ST_ADD_WR,
      ST_RD_WAIT, ST_RD_DATA, ST_DIV, ST_CLEAR, ST_OUT
   } state_type;
endpackage
`default_nettype wire

@@ rtl/mtc_req_if.sv @@
// ----------------------------------------------------------------------------
// mtc_req_if / mtc_rsp_if
// Valid-ready channels for request and response items.
// ----------------------------------------------------------------------------
`default_nettype none
interface mtc_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          opcode;
   logic signed [31:0]  symbol;
   logic [5:0]          row_index;
   logic [5:0]          col_index;
   modport source (output valid, opcode, symbol, row_index, col_index, input ready);
   modport sink   (input valid, opcode, symbol, row_index, col_index, output ready);
endinterface

interface mtc_rsp_if;
   logic                valid;
   logic                ready;
   logic                accepted;
   logic                was_new;
   logic [5:0]          symbol_index;
   logic [16:0]         probability;
   logic [15:0]         cell_count;
   logic signed [31:0]  row_symbol;
   logic signed [31:0]  col_symbol;
   logic [6:0]          distinct_symbols;
   modport source (output valid, accepted, was_new, symbol_index, probability, cell_count,
                   row_symbol, col_symbol, distinct_symbols, input ready);
   modport sink   (input valid, accepted, was_new, symbol_index, probability, cell_count,
                   row_symbol, col_symbol, distinct_symbols, output ready);
endinterface
`default_nettype wire

@@ rtl/mtc_ram.sv @@
// ----------------------------------------------------------------------------
// mtc_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module mtc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

@@ rtl/mtc_cell.sv @@
// ----------------------------------------------------------------------------
// mtc_cell
// One symbol slot; compares its symbol with the probe passing by and shifts
// the probe on to the next slot.
// ----------------------------------------------------------------------------
`default_nettype none
module mtc_cell #(
   parameter int IDX_BITS = 6
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [31:0]         wr_sym,
   input  wire logic                present,
   input  wire logic                probe_vld_in,
   input  wire logic [31:0]         probe_in,
   input  wire logic                hit_in,
   input  wire logic [IDX_BITS-1:0] hit_idx_in,
   input  wire logic [IDX_BITS-1:0] my_idx,
   output logic                     probe_vld_out,
   output logic [31:0]              probe_out,
   output logic                     hit_out,
   output logic [IDX_BITS-1:0]      hit_idx_out,
   output logic [31:0]              sym_out
);
   logic [31:0] sym_ff;
   logic        match;
   assign match = present && (sym_ff == probe_in) && !hit_in;
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sym_ff <= wr_sym;
      end
      probe_vld_out <= probe_vld_in;
      probe_out     <= probe_in;
      hit_out       <= hit_in || match;
      hit_idx_out   <= match ? my_idx : hit_idx_in;
   end
   assign sym_out = sym_ff;
endmodule
`default_nettype wire

@@ rtl/mtc_div.sv @@
// ----------------------------------------------------------------------------
// mtc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mtc_div #(
   parameter int NB = 41,
   parameter int DB = 24
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NB-1:0] num,
   input  wire logic [DB-1:0] den,
   output logic               done,
   output logic [NB-1:0]      quo
);
   localparam int CB = $clog2(NB + 1);
   logic [NB-1:0] q_ff;
   logic [DB:0]   r_ff;
   logic [DB-1:0] d_ff;
   logic [CB-1:0] cnt_ff;
   logic          busy_ff;
   logic [DB:0]   trial;
   logic [DB:0]   diff;
   assign trial = {r_ff[DB-1:0], q_ff[NB-1]};
   assign diff  = trial - {1'b0, d_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CB'(NB);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CB'(1)) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
      if (start) begin
         q_ff <= num;
         r_ff <= '0;
         d_ff <= den;
      end else if (busy_ff) begin
         if (!diff[DB]) begin
            r_ff <= diff;
            q_ff <= {q_ff[NB-2:0], 1'b1};
         end else begin
            r_ff <= trial;
            q_ff <= {q_ff[NB-2:0], 1'b0};
         end
      end
   end
   assign quo = q_ff;
endmodule
`default_nettype wire

@@ rtl/markov_transition_counter.sv @@
// ----------------------------------------------------------------------------
// markov_transition_counter
// Symbol indexing, transition counting and probability readout.
// Add: the probe moves down the cell row, then the count entry is read and
//   updated in ST_ADD_RD, ST_ADD_WAIT and ST_ADD_WR before the response.
// Read: entry fetched, then the bit-serial divider; out of range skips it.
// Clear: all MAX_SYMBOLS*MAX_SYMBOLS count entries, one count entry per cycle.
// One item in flight at a time; the next is taken the cycle after the response.
// Reset runs the same clearing pass; the input is held off until it finishes.
// ----------------------------------------------------------------------------
`default_nettype none
module markov_transition_counter #(
   parameter int COUNT_BITS  = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mtc_req_if.sink    req,
   mtc_rsp_if.source  rsp,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data
);
   localparam int MAX_SYMBOLS = mtc_pkg::MAX_SYMBOLS;
   localparam int IB = $clog2(MAX_SYMBOLS);
   localparam int CB = $clog2(MAX_SYMBOLS + 1);
   localparam int AB = 2 * IB;
   localparam int TB = mtc_pkg::TOTAL_BITS;
   localparam int NB = COUNT_BITS + 17;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam logic [TB-1:0] TMAX = '1;

   mtc_pkg::state_type state_ff, state_in;
   logic [6:0]    limit_ff;
   logic [CB-1:0] count_ff;
   logic [IB-1:0] prev_ff;
   logic          prev_vld_ff;
   logic [1:0]    op_ff;
   logic [31:0]   sym_ff;
   logic [5:0]    row_ff, col_ff;
   logic [AB-1:0] clr_ff;
   logic [7:0]    wait_ff;
   logic          rv_ff;
   logic          r_acc_ff, r_new_ff;
   logic [5:0]    r_idx_ff;
   logic [16:0]   r_prob_ff;
   logic [15:0]   r_cnt_ff;
   logic [31:0]   r_rsym_ff, r_csym_ff;
   logic [IB-1:0] idx_ff;

   // cell chain
   logic          pv [MAX_SYMBOLS+1];
   logic [31:0]   pd [MAX_SYMBOLS+1];
   logic          ph [MAX_SYMBOLS+1];
   logic [IB-1:0] pi [MAX_SYMBOLS+1];
   logic [31:0]   syms [MAX_SYMBOLS];
   logic          start_probe;
   logic          add_new;
   assign pv[0] = start_probe;
   assign pd[0] = sym_ff;
   assign ph[0] = 1'b0;
   assign pi[0] = '0;

   for (genvar g = 0; g < MAX_SYMBOLS; g++) begin : g_cell
      mtc_cell #(.IDX_BITS(IB)) u_cell (
         .clock(clock),
         .wr_en(add_new && count_ff == CB'(g)),
         .wr_sym(sym_ff),
         .present(count_ff > CB'(g)),
         .probe_vld_in(pv[g]), .probe_in(pd[g]), .hit_in(ph[g]), .hit_idx_in(pi[g]),
         .my_idx(IB'(g)),
         .probe_vld_out(pv[g+1]), .probe_out(pd[g+1]), .hit_out(ph[g+1]),
         .hit_idx_out(pi[g+1]),
         .sym_out(syms[g])
      );
   end

   // memories and divider
   logic                  m_we;
   logic [AB-1:0]         m_addr;
   logic [COUNT_BITS-1:0] m_wd, m_rd;
   mtc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_SYMBOLS * MAX_SYMBOLS)) u_ram (
      .clock(clock), .wr_en(m_we), .addr(m_addr), .wr_data(m_wd), .rd_data(m_rd)
   );
   logic                  t_we;
   logic [IB-1:0]         t_addr;
   logic [TB-1:0]         t_wd, t_rd;
   mtc_ram #(.WIDTH(TB), .DEPTH(MAX_SYMBOLS)) u_tot_ram (
      .clock(clock), .wr_en(t_we), .addr(t_addr), .wr_data(t_wd), .rd_data(t_rd)
   );
   logic          d_start, d_done;
   logic [NB-1:0] d_quo;
   logic [NB-1:0] d_num;
   logic [TB-1:0] d_den;
   assign d_num = (t_rd == '0) ? NB'(17'h10000) : NB'({m_rd, 16'd0});
   assign d_den = (t_rd == '0) ? TB'(count_ff) : t_rd;
   mtc_div #(.NB(NB), .DB(TB)) u_div (
      .clock(clock), .reset(reset), .start(d_start),
      .num(d_num), .den(d_den), .done(d_done), .quo(d_quo)
   );

   logic [IB:0] eff_limit;
   assign eff_limit = (limit_ff > 7'(MAX_SYMBOLS)) ? (IB+1)'(MAX_SYMBOLS)
                                                    : (IB+1)'(limit_ff);
   logic found;
   assign found = ph[MAX_SYMBOLS];
   assign add_new = (state_ff == mtc_pkg::ST_SEARCH) && pv[MAX_SYMBOLS] && !found
                    && ((IB+1)'(count_ff) < eff_limit);
   logic rd_ok;
   assign rd_ok = (CB'(row_ff) < count_ff) && (CB'(col_ff) < count_ff)
                  && (7'(row_ff) < 7'(MAX_SYMBOLS)) && (7'(col_ff) < 7'(MAX_SYMBOLS));

   assign req.ready = (state_ff == mtc_pkg::ST_IDLE);
   logic acc;
   assign acc = req.valid && req.ready;

   always_comb begin
      state_in    = state_ff;
      start_probe = 1'b0;
      m_we        = 1'b0;
      m_addr      = {prev_ff, idx_ff};
      m_wd        = m_rd + 1'b1;
      t_we        = 1'b0;
      t_addr      = prev_ff;
      t_wd        = t_rd + 1'b1;
      d_start     = 1'b0;
      unique case (state_ff)
         mtc_pkg::ST_IDLE: begin
            m_addr = {row_ff[IB-1:0], col_ff[IB-1:0]};
            t_addr = row_ff[IB-1:0];
            if (acc) begin
               unique case (mtc_pkg::op_type'(req.opcode))
                  mtc_pkg::OP_ADD:   state_in = mtc_pkg::ST_SEARCH;
                  mtc_pkg::OP_READ:  state_in = mtc_pkg::ST_RD_WAIT;
                  mtc_pkg::OP_CLEAR: state_in = mtc_pkg::ST_CLEAR;
                  default:           state_in = mtc_pkg::ST_OUT;
               endcase
            end
         end
         mtc_pkg::ST_SEARCH: begin
            start_probe = (wait_ff == 8'd0);
            if (pv[MAX_SYMBOLS]) begin
               state_in = mtc_pkg::ST_ADD_RD;
            end
         end
         mtc_pkg::ST_ADD_RD:   state_in = mtc_pkg::ST_ADD_WAIT;
         mtc_pkg::ST_ADD_WAIT: state_in = mtc_pkg::ST_ADD_WR;
         mtc_pkg::ST_ADD_WR: begin
            m_we     = r_acc_ff && prev_vld_ff && (m_rd != CMAX);
            t_we     = r_acc_ff && prev_vld_ff && (m_rd != CMAX) && (t_rd != TMAX);
            state_in = mtc_pkg::ST_OUT;
         end
         mtc_pkg::ST_RD_WAIT: begin
            m_addr   = {row_ff[IB-1:0], col_ff[IB-1:0]};
            t_addr   = row_ff[IB-1:0];
            state_in = mtc_pkg::ST_RD_DATA;
         end
         mtc_pkg::ST_RD_DATA: begin
            m_addr = {row_ff[IB-1:0], col_ff[IB-1:0]};
            t_addr = row_ff[IB-1:0];
            if (wait_ff == 8'd1) begin
               d_start  = rd_ok;
               state_in = rd_ok ? mtc_pkg::ST_DIV : mtc_pkg::ST_OUT;
            end
         end
         mtc_pkg::ST_DIV: begin
            if (d_done) state_in = mtc_pkg::ST_OUT;
         end
         mtc_pkg::ST_CLEAR: begin
            m_we   = 1'b1;
            m_addr = clr_ff;
            m_wd   = '0;
            t_we   = 1'b1;
            t_addr = clr_ff[IB-1:0];
            t_wd   = '0;
            if (clr_ff == '1) begin
               state_in = (op_ff == mtc_pkg::OP_CLEAR) ? mtc_pkg::ST_OUT : mtc_pkg::ST_IDLE;
            end
         end
         mtc_pkg::ST_OUT: begin
            if (!rsp.valid || rsp.ready) state_in = mtc_pkg::ST_IDLE;
         end
         default: state_in = mtc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mtc_pkg::ST_CLEAR;
         limit_ff    <= mtc_pkg::LIMIT_RESET;
         count_ff    <= '0;
         prev_ff     <= '0;
         prev_vld_ff <= 1'b0;
         op_ff       <= mtc_pkg::OP_NONE;
         clr_ff      <= '0;
         rv_ff       <= 1'b0;
         wait_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en && csr_wr_data != 7'd0) limit_ff <= csr_wr_data;
         if (rsp.valid && rsp.ready) rv_ff <= 1'b0;
         wait_ff <= (state_in == state_ff) ? wait_ff + 8'd1 : 8'd0;
         if (acc) begin
            op_ff  <= req.opcode;
            sym_ff <= req.symbol;
            row_ff <= req.row_index;
            col_ff <= req.col_index;
            r_acc_ff <= 1'b0; r_new_ff <= 1'b0; r_idx_ff <= '0; r_prob_ff <= '0;
            r_cnt_ff <= '0; r_rsym_ff <= '0; r_csym_ff <= '0;
            clr_ff <= '0;
         end
         unique case (state_ff)
            mtc_pkg::ST_SEARCH: if (pv[MAX_SYMBOLS]) begin
               if (found) begin
                  idx_ff <= pi[MAX_SYMBOLS];
                  r_acc_ff <= 1'b1;
                  r_idx_ff <= 6'(pi[MAX_SYMBOLS]);
               end else if (add_new) begin
                  idx_ff <= IB'(count_ff);
                  count_ff <= count_ff + 1'b1;
                  r_acc_ff <= 1'b1; r_new_ff <= 1'b1;
                  r_idx_ff <= 6'(count_ff);
               end
            end
            mtc_pkg::ST_ADD_WR: if (r_acc_ff) begin
               prev_ff <= idx_ff;
               prev_vld_ff <= 1'b1;
            end
            mtc_pkg::ST_RD_DATA: if (wait_ff == 8'd1 && rd_ok) begin
               r_acc_ff  <= 1'b1;
               r_cnt_ff  <= 16'(m_rd);
               r_rsym_ff <= syms[row_ff[IB-1:0]];
               r_csym_ff <= syms[col_ff[IB-1:0]];
            end
            mtc_pkg::ST_DIV: if (d_done)
               r_prob_ff <= (d_quo > NB'(65536)) ? 17'd65536 : 17'(d_quo);
            mtc_pkg::ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               count_ff <= '0; prev_ff <= '0; prev_vld_ff <= 1'b0;
            end
            default: ;
         endcase
         if (state_ff != mtc_pkg::ST_OUT && state_in == mtc_pkg::ST_OUT) rv_ff <= 1'b1;
      end
   end

   assign rsp.valid            = rv_ff;
   assign rsp.accepted         = r_acc_ff;
   assign rsp.was_new          = r_new_ff;
   assign rsp.symbol_index     = r_idx_ff;
   assign rsp.probability      = r_prob_ff;
   assign rsp.cell_count       = r_cnt_ff;
   assign rsp.row_symbol       = r_rsym_ff;
   assign rsp.col_symbol       = r_csym_ff;
   assign rsp.distinct_symbols = 7'(count_ff);

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("ready while a response waits");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.accepted)
         && $stable(rsp.probability) && $stable(rsp.row_symbol)
         && $stable(rsp.distinct_symbols)) else $error("response changed while held");
   a_count_lim: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(MAX_SYMBOLS)) else $error("count above capacity");
   a_new_acc: assert property (@(posedge clock) disable iff (reset)
      rv_ff && r_new_ff |-> r_acc_ff) else $error("new without accept");
endmodule
`default_nettype wire
